>>> rtl/core/dqs_pkg.sv
// ----------------------------------------------------------------------------
// dqs_pkg
// Shared types, sizes and helpers for the double-ended queue with search.
// ----------------------------------------------------------------------------
package dqs_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int KIND_W = 3;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int POS_W  = 4;

    typedef enum logic [KIND_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_SEARCH     = 3'd4,
        REQ_DUMP       = 3'd5
    } req_kind_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_RDATA,
        SRC_VALUE
    } out_src_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_EXEC,
        CS_RESP,
        CS_SCAN
    } ctl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic     capture;
        logic     push_front;
        logic     push_back;
        logic     pop_front;
        logic     pop_back;
        logic     scan_start;
        logic     scan_next;
        logic     out_load;
        status_t  out_status;
        out_src_t out_src;
        logic     out_pos_k;
        logic     out_last;
    } dqs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              empty;
        logic              full;
        logic              match;
        logic              at_end;
        logic              out_free;
        logic [CNT_W-1:0]  level;
    } dqs_stat_t;

    // ring slot at distance k from the front, k < DEPTH
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] f,
                                                 input logic [CNT_W-1:0] k);
        logic [IDX_W:0] s;
        s = {1'b0, f} + (IDX_W+1)'(k);
        if (s >= (IDX_W+1)'(DEPTH))
            s = s - (IDX_W+1)'(DEPTH);
        return s[IDX_W-1:0];
    endfunction

endpackage

>>> rtl/core/dqs_ctrl.sv
// ----------------------------------------------------------------------------
// dqs_ctrl
// Request sequencer: decodes the captured request and steps the datapath.
// ----------------------------------------------------------------------------
module dqs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dqs_pkg::dqs_stat_t stat,
    output dqs_pkg::dqs_cmd_t  cmd
);
    import dqs_pkg::*;

    ctl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= CS_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.out_status = ST_OK;
        cmd.out_src    = SRC_ZERO;
        cmd.out_last   = 1'b1;
        s_ready        = 1'b0;

        unique case (state_reg)
            CS_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid)
                    state_next = CS_EXEC;
            end
            CS_EXEC: begin
                unique case (stat.kind)
                    REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                        if (stat.out_free) begin
                            cmd.out_load = 1'b1;
                            if (stat.full) begin
                                cmd.out_status = ST_FULL;
                            end else begin
                                cmd.push_front = (stat.kind == REQ_PUSH_FRONT);
                                cmd.push_back  = (stat.kind == REQ_PUSH_BACK);
                            end
                            state_next = CS_IDLE;
                        end
                    end
                    REQ_POP_FRONT, REQ_POP_BACK, REQ_SEARCH, REQ_DUMP: begin
                        if (stat.empty) begin
                            if (stat.out_free) begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = ST_EMPTY;
                                state_next     = CS_IDLE;
                            end
                        end else if (stat.kind == REQ_POP_FRONT) begin
                            cmd.pop_front = 1'b1;
                            state_next    = CS_RESP;
                        end else if (stat.kind == REQ_POP_BACK) begin
                            cmd.pop_back = 1'b1;
                            state_next   = CS_RESP;
                        end else begin
                            cmd.scan_start = 1'b1;
                            state_next     = CS_SCAN;
                        end
                    end
                    default: state_next = CS_IDLE;  // unused codes: no result
                endcase
            end
            CS_RESP: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_src  = SRC_RDATA;
                    state_next   = CS_IDLE;
                end
            end
            CS_SCAN: begin
                if (stat.kind == REQ_DUMP) begin
                    if (stat.out_free) begin
                        cmd.out_load  = 1'b1;
                        cmd.out_src   = SRC_RDATA;
                        cmd.out_pos_k = 1'b1;
                        cmd.out_last  = stat.at_end;
                        if (stat.at_end)
                            state_next = CS_IDLE;
                        else
                            cmd.scan_next = 1'b1;
                    end
                end else if (stat.match) begin
                    if (stat.out_free) begin
                        cmd.out_load  = 1'b1;
                        cmd.out_src   = SRC_VALUE;
                        cmd.out_pos_k = 1'b1;
                        state_next    = CS_IDLE;
                    end
                end else if (stat.at_end) begin
                    if (stat.out_free) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = ST_NOT_FOUND;
                        state_next     = CS_IDLE;
                    end
                end else begin
                    cmd.scan_next = 1'b1;
                end
            end
            default: state_next = CS_IDLE;
        endcase
    end

endmodule

>>> rtl/core/dqs_dp.sv
// ----------------------------------------------------------------------------
// dqs_dp
// Ring storage, front/occupancy pointers, scan counter and result register.
// ----------------------------------------------------------------------------
module dqs_dp (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [dqs_pkg::KIND_W-1:0]   s_kind,
    input  logic signed [dqs_pkg::DATA_W-1:0] s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [dqs_pkg::STAT_W-1:0]   m_status,
    output logic signed [dqs_pkg::DATA_W-1:0] m_data,
    output logic [dqs_pkg::POS_W-1:0]    m_position,
    output logic                         m_last_of_run,
    input  dqs_pkg::dqs_cmd_t            cmd,
    output dqs_pkg::dqs_stat_t           stat
);
    import dqs_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    logic [KIND_W-1:0] kind_reg;
    logic [DATA_W-1:0] value_reg;
    logic [IDX_W-1:0]  front_reg, front_next;
    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [DATA_W-1:0] rd_data_reg;

    logic              wr_en, rd_en;
    logic [IDX_W-1:0]  wr_addr, rd_addr, front_dec;

    logic              m_valid_reg;
    logic [STAT_W-1:0] status_reg;
    logic [DATA_W-1:0] data_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              last_reg;
    logic [DATA_W-1:0] data_sel;

    assign front_dec = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - 1'b1;

    always_comb begin
        wr_en      = 1'b0;
        wr_addr    = front_reg;
        rd_en      = 1'b0;
        rd_addr    = front_reg;
        front_next = front_reg;
        occ_next   = occ_reg;
        k_next     = k_reg;
        priority if (cmd.push_front) begin
            wr_en      = 1'b1;
            wr_addr    = front_dec;
            front_next = front_dec;
            occ_next   = occ_reg + 1'b1;
        end else if (cmd.push_back) begin
            wr_en    = 1'b1;
            wr_addr  = slot_of(front_reg, occ_reg);
            occ_next = occ_reg + 1'b1;
        end else if (cmd.pop_front) begin
            rd_en      = 1'b1;
            front_next = slot_of(front_reg, CNT_W'(1));
            occ_next   = occ_reg - 1'b1;
        end else if (cmd.pop_back) begin
            rd_en    = 1'b1;
            rd_addr  = slot_of(front_reg, occ_reg - 1'b1);
            occ_next = occ_reg - 1'b1;
        end else if (cmd.scan_start) begin
            rd_en  = 1'b1;
            k_next = '0;
        end else if (cmd.scan_next) begin
            rd_en   = 1'b1;
            k_next  = k_reg + 1'b1;
            rd_addr = slot_of(front_reg, k_reg + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en)
            mem[wr_addr] <= value_reg;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            occ_reg   <= '0;
        end else begin
            front_reg <= front_next;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg <= k_next;
        if (cmd.capture) begin
            kind_reg  <= s_kind;
            value_reg <= s_value;
        end
    end

    always_comb begin
        unique case (cmd.out_src)
            SRC_RDATA: data_sel = rd_data_reg;
            SRC_VALUE: data_sel = value_reg;
            default:   data_sel = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            m_valid_reg <= 1'b0;
        else if (cmd.out_load)
            m_valid_reg <= 1'b1;
        else if (m_ready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            status_reg <= cmd.out_status;
            data_reg   <= data_sel;
            pos_reg    <= cmd.out_pos_k ? POS_W'(k_reg) : '0;
            last_reg   <= cmd.out_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_data        = data_reg;
    assign m_position    = pos_reg;
    assign m_last_of_run = last_reg;

    assign stat.kind     = kind_reg;
    assign stat.empty    = (occ_reg == '0);
    assign stat.full     = (occ_reg == CNT_W'(DEPTH));
    assign stat.match    = (rd_data_reg == value_reg);
    assign stat.at_end   = ({1'b0, k_reg} + 1'b1) == {1'b0, occ_reg};
    assign stat.out_free = !m_valid_reg || m_ready;
    assign stat.level    = occ_reg;

endmodule

>>> rtl/core/double_ended_queue_with_search_core.sv
// ----------------------------------------------------------------------------
// double_ended_queue_with_search_core
// Bounded deque of 32-bit words with front-to-back search and in-order dump.
// ----------------------------------------------------------------------------
// One request is taken at a time. A push is decoded in the execute state,
// which registers its result once the result register is free; a pop adds
// one registered read of the ring memory. Search and dump walk the stored
// entries through that single read port, one entry per cycle while the
// result side does not stall: a dump waits on it for every entry, a search
// only for its final answer. Pop, search or dump on an empty queue answers
// EMPTY without reading the ring. A dump emits one result per entry with
// last_of_run on the final one. A finished result sits in an output register,
// so the next request is taken while it waits. Codes 6 and 7 are dropped
// without a result. Storage has no reset; only occupied slots are ever read.
module double_ended_queue_with_search_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [dqs_pkg::KIND_W-1:0]        s_kind,
    input  logic signed [dqs_pkg::DATA_W-1:0] s_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [dqs_pkg::STAT_W-1:0]        m_status,
    output logic signed [dqs_pkg::DATA_W-1:0] m_data,
    output logic [dqs_pkg::POS_W-1:0]         m_position,
    output logic                              m_last_of_run
);
    import dqs_pkg::*;

    dqs_cmd_t  cmd;
    dqs_stat_t stat;

    dqs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    dqs_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_kind        (s_kind),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_data        (m_data),
        .m_position    (m_position),
        .m_last_of_run (m_last_of_run),
        .cmd           (cmd),
        .stat          (stat)
    );

    // occupancy never runs past the ring size
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.level <= CNT_W'(DEPTH))
        else $error("occupancy above depth");

    // one request in flight: no accept right after an accept
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while busy");

    // the result register is only loaded when it is free
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> stat.out_free)
        else $error("result overwritten before taken");

endmodule

>>> tb/double_ended_queue_with_search_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_ended_queue_with_search_core_tb
// Self-checking bench for the bounded deque with search and dump. A clocked
// driver offers requests from a backlog with random gaps, a clocked monitor
// takes results with random stalls and compares them against a mirror of
// the deque that is updated at every accepted request.
// ----------------------------------------------------------------------------
module double_ended_queue_with_search_core_tb;

    import dqs_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
    localparam int RANDOM_REQS    = 150;
    localparam int HOLD_AT        = 45;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 40;

    typedef struct {
        logic [KIND_W-1:0]        kind;
        logic signed [DATA_W-1:0] value;
        int                       gap;
        bit                       drain;
    } req_item_t;

    typedef struct {
        status_t                  status;
        logic signed [DATA_W-1:0] data;
        logic [POS_W-1:0]         pos;
        logic                     last;
    } deque_result_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [KIND_W-1:0]         s_kind = '0;
    logic signed [DATA_W-1:0]  s_value = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [STAT_W-1:0]         m_status;
    logic signed [DATA_W-1:0]  m_data;
    logic [POS_W-1:0]          m_position;
    logic                      m_last_of_run;

    req_item_t                 req_backlog[$];
    deque_result_t             due_results[$];
    logic signed [DATA_W-1:0]  pushed_values[$];

    // mirror of the deque contents
    logic signed [DATA_W-1:0]  mirror_ring[DEPTH];
    int                        mirror_head = 0;
    int                        mirror_fill = 0;

    int  reqs_total = 0;
    int  reqs_counted = 0;
    int  accepted_reqs = 0;
    int  results_owed = 0;
    int  results_taken = 0;
    int  mismatches = 0;
    int  idle_cycles = 0;
    int  hold_left = 0;
    bit  hold_fired = 1'b0;
    bit  calm_stim = 1'b0;
    bit  drain_next = 1'b0;

    double_ended_queue_with_search_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_data        (m_data),
        .m_position    (m_position),
        .m_last_of_run (m_last_of_run)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic void owe_result(status_t st, logic signed [DATA_W-1:0] d,
                                       int pos, bit last);
        deque_result_t r;
        r.status = st;
        r.data   = d;
        r.pos    = POS_W'(pos);
        r.last   = last;
        due_results.push_back(r);
    endfunction

    // Apply one accepted request to the mirror; returns the number of results owed.
    function automatic int deque_apply(logic [KIND_W-1:0] kind,
                                       logic signed [DATA_W-1:0] value);
        int k;
        int slot;
        case (kind)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                if (mirror_fill >= DEPTH) begin
                    owe_result(ST_FULL, '0, 0, 1'b1);
                end else begin
                    if (kind == REQ_PUSH_FRONT) begin
                        mirror_head = (mirror_head + DEPTH - 1) % DEPTH;
                        mirror_ring[mirror_head] = value;
                    end else begin
                        mirror_ring[(mirror_head + mirror_fill) % DEPTH] = value;
                    end
                    mirror_fill++;
                    owe_result(ST_OK, '0, 0, 1'b1);
                end
                return 1;
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
                if (mirror_fill == 0) begin
                    owe_result(ST_EMPTY, '0, 0, 1'b1);
                end else if (kind == REQ_POP_FRONT) begin
                    owe_result(ST_OK, mirror_ring[mirror_head], 0, 1'b1);
                    mirror_head = (mirror_head + 1) % DEPTH;
                    mirror_fill--;
                end else begin
                    slot = (mirror_head + mirror_fill - 1) % DEPTH;
                    owe_result(ST_OK, mirror_ring[slot], 0, 1'b1);
                    mirror_fill--;
                end
                return 1;
            end
            REQ_SEARCH: begin
                if (mirror_fill == 0) begin
                    owe_result(ST_EMPTY, '0, 0, 1'b1);
                    return 1;
                end
                for (k = 0; k < mirror_fill; k++) begin
                    if (mirror_ring[(mirror_head + k) % DEPTH] == value) begin
                        owe_result(ST_OK, value, k, 1'b1);
                        return 1;
                    end
                end
                owe_result(ST_NOT_FOUND, '0, 0, 1'b1);
                return 1;
            end
            REQ_DUMP: begin
                if (mirror_fill == 0) begin
                    owe_result(ST_EMPTY, '0, 0, 1'b1);
                    return 1;
                end
                for (k = 0; k < mirror_fill; k++)
                    owe_result(ST_OK, mirror_ring[(mirror_head + k) % DEPTH], k,
                               k == mirror_fill - 1);
                return mirror_fill;
            end
            default: return 0;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return {1'b1, {(DATA_W-1){1'b0}}};
            1: return {1'b0, {(DATA_W-1){1'b1}}};
            2: return '0;
            3: return '1;
            // small set so that duplicates and repeated matches show up
            4, 5: return DATA_W'($urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] search_value();
        if (pushed_values.size() > 0 && $urandom_range(0, 2) != 0)
            return pushed_values[$urandom_range(0, pushed_values.size() - 1)];
        return rand_value();
    endfunction

    function automatic void add_req(logic [KIND_W-1:0] kind,
                                    logic signed [DATA_W-1:0] value);
        req_item_t it;
        it.kind  = kind;
        it.value = value;
        it.gap   = calm_stim ? 0 : $urandom_range(0, 6);
        it.drain = drain_next;
        drain_next = 1'b0;
        req_backlog.push_back(it);
        reqs_total++;
        if (kind != KIND_SPARE_LO && kind != KIND_SPARE_HI)
            reqs_counted++;
        if (kind == REQ_PUSH_FRONT || kind == REQ_PUSH_BACK) begin
            pushed_values.push_back(value);
            if (pushed_values.size() > 32)
                void'(pushed_values.pop_front());
        end
    endfunction

    function automatic void add_push(logic signed [DATA_W-1:0] value);
        add_req($urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, value);
    endfunction

    function automatic void add_pop();
        add_req($urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT, '0);
    endfunction

    // Driver: offers requests from the backlog, holding each until accepted.
    req_item_t next_req;
    bit        have_next = 1'b0;
    int        next_gap = 0;

    always @(posedge aclk) begin
        int made;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_kind  <= '0;
            s_value <= '0;
        end else begin
            made = 0;
            if (s_valid && s_ready) begin
                made = deque_apply(s_kind, s_value);
                accepted_reqs <= accepted_reqs + 1;
                results_owed  <= results_owed + made;
            end
            if (!s_valid || s_ready) begin
                if (have_next && next_gap == 0 &&
                    !(next_req.drain && results_owed + made != results_taken)) begin
                    s_valid   <= 1'b1;
                    s_kind    <= next_req.kind;
                    s_value   <= next_req.value;
                    have_next = 1'b0;
                end else begin
                    s_valid <= 1'b0;
                    if (have_next && next_gap > 0)
                        next_gap--;
                end
                if (!have_next && req_backlog.size() > 0) begin
                    next_req  = req_backlog.pop_front();
                    next_gap  = next_req.gap;
                    have_next = 1'b1;
                end
            end
        end
    end

    // One long result-side hold-off so the block backs up into its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left  <= 0;
            hold_fired <= 1'b0;
        end else if (!hold_fired && accepted_reqs >= HOLD_AT) begin
            hold_left  <= HOLD_CYCLES;
            hold_fired <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: takes results with random stalls and checks them in order.
    int            rcv_gap = 0;
    int            rcv_calm = 0;
    deque_result_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_taken <= results_taken + 1;
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: status %0d data %0d pos %0d last %0b",
                                 m_status, m_data, m_position, m_last_of_run);
                end else begin
                    want = due_results.pop_front();
                    if (m_status !== want.status || m_data !== want.data ||
                        m_position !== want.pos || m_last_of_run !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result mismatch: expected status %0d data %0d pos %0d",
                                      " last %0b, got status %0d data %0d pos %0d last %0b"},
                                     want.status, want.data, want.pos, want.last,
                                     m_status, m_data, m_position, m_last_of_run);
                    end
                end
                if (rcv_calm > 0) begin
                    rcv_calm--;
                    rcv_gap = 0;
                end else if ($urandom_range(0, 24) == 0) begin
                    rcv_calm = 20;
                    rcv_gap  = 0;
                end else begin
                    rcv_gap = $urandom_range(0, 6);
                end
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
            end else if (rcv_gap > 0) begin
                rcv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("stalled for %0d cycles", idle_cycles);
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int len;
        int i;
        bit second_drain;
        second_drain = 1'b0;

        // directed: empty cases, extremes, duplicates, spare codes
        add_req(REQ_POP_FRONT, '0);
        add_req(REQ_POP_BACK, '0);
        add_req(REQ_SEARCH, 32'sd5);
        add_req(REQ_DUMP, '0);
        add_req(REQ_PUSH_FRONT, {1'b1, {(DATA_W-1){1'b0}}});
        add_req(REQ_PUSH_BACK, {1'b0, {(DATA_W-1){1'b1}}});
        add_req(REQ_PUSH_FRONT, '0);
        add_req(REQ_PUSH_BACK, '1);
        add_req(REQ_PUSH_BACK, '0);
        add_req(REQ_SEARCH, '1);
        add_req(REQ_SEARCH, '0);
        add_req(REQ_SEARCH, {1'b0, {(DATA_W-1){1'b1}}});
        add_req(REQ_SEARCH, 32'sd12345);
        add_req(REQ_DUMP, '0);
        add_req(KIND_SPARE_LO, '1);
        add_req(KIND_SPARE_HI, 32'h5a5a_a5a5);
        add_req(REQ_POP_FRONT, '0);
        add_req(REQ_POP_BACK, '0);
        add_req(REQ_DUMP, '0);

        // random: fill/search/dump/drain runs, mixed traffic, dump/search pairs and noise
        drain_next = 1'b1;
        while (reqs_counted < RANDOM_REQS) begin
            calm_stim = ($urandom_range(0, 3) == 0);
            if (!second_drain && reqs_counted >= 100) begin
                drain_next   = 1'b1;
                second_drain = 1'b1;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    len = $urandom_range(1, DEPTH + 4);
                    for (i = 0; i < len; i++)
                        add_push(rand_value());
                    repeat ($urandom_range(1, 3))
                        add_req(REQ_SEARCH, search_value());
                    add_req(REQ_DUMP, '0);
                    repeat ($urandom_range(1, len + 2))
                        add_pop();
                end
                4, 5, 6: begin
                    repeat ($urandom_range(3, 10)) begin
                        case ($urandom_range(0, 7))
                            0, 1, 2: add_push(rand_value());
                            3, 4:    add_pop();
                            5, 6:    add_req(REQ_SEARCH, search_value());
                            default: add_req(REQ_DUMP, $urandom);
                        endcase
                    end
                end
                7: begin
                    repeat ($urandom_range(1, 3))
                        add_req($urandom_range(0, 1) ? KIND_SPARE_HI : KIND_SPARE_LO,
                                $urandom);
                    add_pop();
                end
                default: begin
                    add_req(REQ_DUMP, $urandom);
                    add_req(REQ_SEARCH, search_value());
                end
            endcase
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted_reqs != reqs_total || due_results.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0 && due_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/dqs_pkg.sv
rtl/core/dqs_ctrl.sv
rtl/core/dqs_dp.sv
rtl/core/double_ended_queue_with_search_core.sv
tb/double_ended_queue_with_search_core_tb.sv
